### rtl/ssd_pkg.sv
// Shared constants, types and helper functions for the sparse set dictionary.
package ssd_pkg;

    localparam int KEY_SPACE  = 1024;
    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;

    // Fixed port field widths
    localparam int KEY_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ECNT_W  = 9;

    localparam int MAP_AW  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        logic [SLOT_W-1:0] data;
    } t_map_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_slot_wr;

    function automatic logic [MAP_AW-1:0] map_addr(input logic [KEY_W-1:0] key);
        return MAP_AW'(key);
    endfunction

    function automatic logic key_in_range(input logic [KEY_W-1:0] key);
        return 32'(key) < KEY_SPACE;
    endfunction

    // Sign-extend or truncate the port value to the stored width
    function automatic logic [VALUE_BITS-1:0] to_store(input logic [VAL_W-1:0] v);
        logic [VALUE_BITS+VAL_W-1:0] ext;
        ext = {{VALUE_BITS{v[VAL_W-1]}}, v};
        return ext[VALUE_BITS-1:0];
    endfunction

    // Low port-width bits of a stored value, zero-filled when narrower
    function automatic logic [VAL_W-1:0] from_store(input logic [VALUE_BITS-1:0] s);
        logic [VALUE_BITS+VAL_W-1:0] ext;
        ext = {{VAL_W{1'b0}}, s};
        return ext[VAL_W-1:0];
    endfunction

endpackage

### rtl/ssd_map_ram.sv
// Key-to-slot map memory with a zeroing sweep after reset.
module ssd_map_ram
    import ssd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [MAP_AW-1:0] i_rd_addr,
    output logic [SLOT_W-1:0] o_rd_data,
    input  t_map_wr           i_wr,
    output logic              o_ready
);

    logic [SLOT_W-1:0] r_mem [KEY_SPACE];
    logic [SLOT_W-1:0] r_rd_data;
    logic [MAP_AW-1:0] r_sweep_addr;
    logic              r_sweep_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweep_busy <= 1'b1;
        end else if (r_sweep_busy) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (r_sweep_addr == MAP_AW'(KEY_SPACE - 1)) begin
                r_sweep_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep_busy) begin
            r_mem[r_sweep_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_sweep_busy;

endmodule

### rtl/ssd_slot_ram.sv
// Dense slot memory: key and value per slot, two read ports and one write port.
module ssd_slot_ram
    import ssd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_addr_a,
    input  logic [SLOT_W-1:0] i_rd_addr_b,
    output t_slot             o_rd_a,
    output t_slot             o_rd_b,
    input  t_slot_wr          i_wr
);

    t_slot r_mem [CAPACITY];
    t_slot r_rd_a;
    t_slot r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

### rtl/sparse_set_dictionary.sv
// Sparse set dictionary: direct-address key/value store whose map memory is never cleared
// by the clear operation. Accepting an item reads the key-to-slot map, S_SLOT reads the slot
// memory at the mapped and the last slot, and S_EXEC, once the output is free, validates the
// entry, writes back the memories as the operation needs and loads the result register. One
// item is in flight at a time; a result may wait in the output register while the next item
// is taken. After reset the map is zeroed in a sweep of all 1024 keys; no item is taken then.
module sparse_set_dictionary
    import ssd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_opcode,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic signed [VAL_W-1:0] o_value_out,
    output logic [ECNT_W-1:0]       o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SLOT = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_opcode               r_op;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [COUNT_W-1:0]    r_count, n_count;

    logic                  r_out_valid;
    t_status               r_status, n_status;
    logic [VAL_W-1:0]      r_vout, n_vout;
    logic [COUNT_W-1:0]    r_ecount;

    logic                  map_ready;
    logic [SLOT_W-1:0]     map_slot;
    t_map_wr               map_wr;
    t_slot                 slot_a, slot_b;
    t_slot_wr              slot_wr;

    logic                  accept;
    logic                  out_free;
    logic                  go;
    logic                  hit;
    logic [SLOT_W-1:0]     last_slot;

    assign accept    = i_in_valid && (r_state == S_IDLE) && map_ready;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign go        = (r_state == S_EXEC) && out_free;
    assign last_slot = SLOT_W'(r_count - 1'b1);

    ssd_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (map_addr(i_key)),
        .o_rd_data (map_slot),
        .i_wr      (map_wr),
        .o_ready   (map_ready)
    );

    ssd_slot_ram u_slot (
        .i_clk       (i_clk),
        .i_rd_en     (r_state == S_SLOT),
        .i_rd_addr_a (map_slot),
        .i_rd_addr_b (last_slot),
        .o_rd_a      (slot_a),
        .o_rd_b      (slot_b),
        .i_wr        (slot_wr)
    );

    // Entry is valid only when the map points below the count and the slot holds the key
    assign hit = key_in_range(r_key) && (COUNT_W'(map_slot) < r_count)
                 && (slot_a.key == r_key);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = ST_OK;
        n_vout   = '0;
        map_wr   = '0;
        slot_wr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (go) begin
                    n_state = S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            if (hit) begin
                                slot_wr.en   = 1'b1;
                                slot_wr.addr = map_slot;
                                slot_wr.data = '{key: r_key, value: r_val};
                            end else if (!key_in_range(r_key)) begin
                                n_status = ST_MISSING;
                            end else if (32'(r_count) >= CAPACITY) begin
                                n_status = ST_FULL;
                            end else begin
                                slot_wr.en   = 1'b1;
                                slot_wr.addr = SLOT_W'(r_count);
                                slot_wr.data = '{key: r_key, value: r_val};
                                map_wr.en    = 1'b1;
                                map_wr.addr  = map_addr(r_key);
                                map_wr.data  = SLOT_W'(r_count);
                                n_count      = r_count + 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (hit) begin
                                n_vout = from_store(slot_a.value);
                            end else begin
                                n_status = ST_MISSING;
                            end
                        end
                        OP_DELETE: begin
                            if (hit) begin
                                // move the last slot into the hole and repoint its key
                                slot_wr.en   = 1'b1;
                                slot_wr.addr = map_slot;
                                slot_wr.data = slot_b;
                                map_wr.en    = key_in_range(slot_b.key);
                                map_wr.addr  = map_addr(slot_b.key);
                                map_wr.data  = map_slot;
                                n_count      = r_count - 1'b1;
                            end else begin
                                n_status = ST_MISSING;
                            end
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_opcode'(i_opcode);
            r_key <= i_key;
            r_val <= to_store(i_value);
        end
        if (go) begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_ecount <= n_count;
        end
    end

    assign o_in_stall    = !((r_state == S_IDLE) && map_ready);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_vout;
    assign o_entry_count = ECNT_W'(r_ecount);

endmodule

### tb/ssd_checker.sv
`timescale 1ns / 1ps
// Checker for the sparse set dictionary: tracks its contents and compares every result item.
module ssd_checker
    import ssd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [1:0]        i_status,
    input  logic [VAL_W-1:0]  i_value_out,
    input  logic [ECNT_W-1:0] i_entry_count,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  value;
        logic [ECNT_W-1:0] count;
    } t_dict_answer;

    logic [SLOT_W-1:0]     key_slot   [KEY_SPACE];
    logic [KEY_W-1:0]      held_key   [CAPACITY];
    logic [VALUE_BITS-1:0] held_value [CAPACITY];
    logic [COUNT_W-1:0]    held_count;

    t_dict_answer answer_q[$];
    int           fails;
    int           results_seen;

    // Apply one operation to the tracked contents and return the answer it gives.
    function automatic t_dict_answer apply_dict_op(input t_opcode op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val);
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] last;
        logic [KEY_W-1:0]  moved;
        logic              hit;
        t_dict_answer      ans;
        slot = key_slot[key];
        // The map is stale after clear or delete: trust it only when the slot agrees
        hit = (COUNT_W'(slot) < held_count) && (held_key[slot] == key);
        ans = '{status: ST_OK, value: '0, count: '0};
        case (op)
            OP_INSERT: begin
                if (hit) begin
                    held_value[slot] = VALUE_BITS'($signed(val));
                end else if (held_count >= COUNT_W'(CAPACITY)) begin
                    ans.status = ST_FULL;
                end else begin
                    held_key[SLOT_W'(held_count)]   = key;
                    held_value[SLOT_W'(held_count)] = VALUE_BITS'($signed(val));
                    key_slot[key] = SLOT_W'(held_count);
                    held_count    = held_count + 1'b1;
                end
            end
            OP_SEARCH: begin
                if (hit)
                    ans.value = VAL_W'(held_value[slot]);
                else
                    ans.status = ST_MISSING;
            end
            OP_DELETE: begin
                if (hit) begin
                    // Fill the hole with the last slot and repoint its key
                    last             = SLOT_W'(held_count - 1'b1);
                    moved            = held_key[last];
                    held_key[slot]   = moved;
                    held_value[slot] = held_value[last];
                    key_slot[moved]  = slot;
                    held_count       = held_count - 1'b1;
                end else begin
                    ans.status = ST_MISSING;
                end
            end
            default: held_count = '0;
        endcase
        ans.count = ECNT_W'(held_count);
        return ans;
    endfunction

    task automatic log_fail(input string msg);
        fails = fails + 1;
        if (fails <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_dict_answer want;
        if (!i_rst_n) begin
            held_count = '0;
            for (int k = 0; k < KEY_SPACE; k++)
                key_slot[k] = '0;
            for (int s = 0; s < CAPACITY; s++) begin
                held_key[s]   = '0;
                held_value[s] = '0;
            end
            answer_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_seen = results_seen + 1;
                if (answer_q.size() == 0) begin
                    log_fail($sformatf({"result %0d with nothing outstanding:",
                                        " status %0d value %h count %0d"},
                                       results_seen, i_status, i_value_out, i_entry_count));
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status || i_value_out !== want.value ||
                        i_entry_count !== want.count)
                        log_fail($sformatf({"result %0d: status exp %0d got %0d,",
                                            " value exp %h got %h,",
                                            " count exp %0d got %0d"},
                                           results_seen, want.status, i_status,
                                           want.value, i_value_out, want.count, i_entry_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(apply_dict_op(t_opcode'(i_opcode), i_key, i_value));
        end
        o_fail_count <= fails;
        o_pending    <= answer_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the sparse set dictionary: stimulus, clock, reset and verdict.
module tb_top;
    import ssd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_opcode      = OP_INSERT;
    logic [KEY_W-1:0]        i_key         = '0;
    logic signed [VAL_W-1:0] i_value       = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic [1:0]              o_status;
    logic signed [VAL_W-1:0] o_value_out;
    logic [ECNT_W-1:0]       o_entry_count;

    bit calm          = 1'b0;
    int cycle_count   = 0;
    int fail_count;
    int pending_results;

    always #5 i_clk = ~i_clk;

    sparse_set_dictionary u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

    ssd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_value_out   (o_value_out),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // Hold results back now and then, except during the calm stretch
    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(0, 99) < 7);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sparse_set_dictionary] ERROR");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_opcode rand_op(input int w_ins, input int w_srch, input int w_del);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            return OP_INSERT;
        if (r < w_ins + w_srch)
            return OP_SEARCH;
        if (r < w_ins + w_srch + w_del)
            return OP_DELETE;
        return OP_CLEAR;
    endfunction

    // Present one item and wait until it is taken
    task automatic send_item(input t_opcode op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        int gap;
        if (!calm && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_key      <= key;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0] pool [32];
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] key;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extremes, overwrite, deletes, stale map after clear
        send_item(OP_SEARCH, 10'd0, 32'h1234_5678);
        send_item(OP_DELETE, 10'd5, '0);
        send_item(OP_INSERT, 10'd0, 32'h8000_0000);
        send_item(OP_INSERT, 10'd1023, 32'h7FFF_FFFF);
        send_item(OP_SEARCH, 10'd0, '0);
        send_item(OP_SEARCH, 10'd1023, '0);
        send_item(OP_INSERT, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_SEARCH, 10'd0, '0);
        send_item(OP_INSERT, 10'd512, 32'h5555_5555);
        send_item(OP_INSERT, 10'd341, 32'hAAAA_AAAA);
        send_item(OP_DELETE, 10'd0, '0);
        send_item(OP_SEARCH, 10'd341, '0);
        send_item(OP_SEARCH, 10'd0, '0);
        send_item(OP_SEARCH, 10'd1023, '0);
        send_item(OP_DELETE, 10'd341, '0);
        send_item(OP_DELETE, 10'd512, '0);
        send_item(OP_DELETE, 10'd1023, '0);
        send_item(OP_INSERT, 10'd7, 32'h0000_0001);
        send_item(OP_INSERT, 10'd8, 32'h0000_0002);
        send_item(OP_CLEAR, 10'd7, 32'hDEAD_BEEF);
        send_item(OP_SEARCH, 10'd7, '0);
        send_item(OP_INSERT, 10'd7, 32'h0000_0003);
        send_item(OP_SEARCH, 10'd7, '0);
        send_item(OP_CLEAR, 10'd0, '0);

        // Small key pool: lots of hits, overwrites and deletes
        foreach (pool[j])
            pool[j] = KEY_W'($urandom());
        repeat (400) begin
            key = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 31)] : KEY_W'($urandom());
            send_item(rand_op(40, 30, 25), key, rand_value());
        end

        // Fill past capacity with distinct keys, without any idling
        send_item(OP_CLEAR, KEY_W'($urandom()), rand_value());
        base   = KEY_W'($urandom());
        stride = KEY_W'($urandom()) | KEY_W'(1);
        calm   = 1'b1;
        for (int i = 0; i < 280; i++)
            send_item(OP_INSERT, KEY_W'(base + KEY_W'(i) * stride), rand_value());
        calm = 1'b0;

        // Churn around the full mark
        repeat (150) begin
            key = KEY_W'(base + KEY_W'($urandom_range(0, 299)) * stride);
            send_item(rand_op(45, 30, 25), key, rand_value());
        end

        // Broad mix, occasional clear, pool refreshed halfway
        for (int i = 0; i < 500; i++) begin
            if (i == 250)
                foreach (pool[j])
                    pool[j] = KEY_W'($urandom());
            key = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 31)] : KEY_W'($urandom());
            send_item(rand_op(38, 30, 30), key, rand_value());
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("[sparse_set_dictionary] OK");
        else
            $display("[sparse_set_dictionary] ERROR");
        $finish;
    end

endmodule
